@@ hdl/mcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared widths, register map and defaults for the max cut segments block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

  localparam int LEN_W       = 11;   // rod and piece lengths
  localparam int CNT_W       = 11;   // piece count
  localparam int ENT_W       = 12;   // table entry: {reach, count}
  localparam int MAX_LEN_DEF = 1024;
  localparam int NUM_PIECE   = 3;

  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [1:0] REG_PIECE_A = 2'd0;
  localparam logic [1:0] REG_PIECE_B = 2'd1;
  localparam logic [1:0] REG_PIECE_C = 2'd2;

  localparam logic [LEN_W-1:0] PIECE_RST = LEN_W'(1);

  typedef struct packed {
    logic             reach;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/mcs_ram.sv @@
// ----------------------------------------------------------------------------
// mcs_ram
// Generic RAM: one write port, NRD read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1025,
  parameter int NRD   = 1,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    rd_addr [NRD],
  output logic      [WIDTH-1:0] rd_data [NRD]
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NRD; k++) begin
      rd_data[k] <= mem[rd_addr[k]];
    end
  end

endmodule

`default_nettype wire

@@ hdl/max_cut_segments_dp_top.sv @@
// ----------------------------------------------------------------------------
// max_cut_segments_dp_top
// Largest number of pieces, from three configured lengths, that exactly
// make up a rod. The count table is filled bottom-up in RAM each item.
// Throughput: one item at a time; one table entry per cycle through the
//   RAM read / update / write-back loop (distance-one hazard forwarded).
// Reset: rst_n synchronous, active low; control cleared, piece lengths = 1.
//   Table RAM is not cleared; every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module max_cut_segments_dp_top
  import mcs_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [LEN_W-1:0]  in_rod_length,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CNT_W-1:0]  out_max_pieces,
  output logic                   out_possible,

  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int DEPTH = MAX_LEN + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (AW > LEN_W) ? AW : LEN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // configuration
  logic [LEN_W-1:0] pl_r [NUM_PIECE];
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PIECE; k++) begin
        pl_r[k] <= PIECE_RST;
      end
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_PIECE_A: pl_r[0] <= cfg_pwdata[LEN_W-1:0];
        REG_PIECE_B: pl_r[1] <= cfg_pwdata[LEN_W-1:0];
        REG_PIECE_C: pl_r[2] <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_PIECE_A: cfg_prdata = CFG_DW'(pl_r[0]);
      REG_PIECE_B: cfg_prdata = CFG_DW'(pl_r[1]);
      REG_PIECE_C: cfg_prdata = CFG_DW'(pl_r[2]);
      default:     cfg_prdata = '0;
    endcase
  end

  // control
  logic [1:0]       state_r, state_nxt;
  logic             iss_on_r, iss_on_nxt;
  logic [AW-1:0]    n_r, n_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic             in_acc;
  logic             too_long;
  logic             iss;

  // stage 2 (RAM data valid)
  logic             s2_vld_r, s2_vld_nxt;
  logic [AW-1:0]    s2_idx_r;
  logic             s2_last_r;
  logic             s2_use_r [NUM_PIECE];
  logic             s2_fwd_r [NUM_PIECE];
  entry_t           fwd_r;

  // issue-side lookups
  logic [CW-1:0]    diff [NUM_PIECE];
  logic [AW-1:0]    addr [NUM_PIECE];
  logic             use_c [NUM_PIECE];
  logic             fwd_c [NUM_PIECE];

  // update
  entry_t           rd_e [NUM_PIECE];
  entry_t           upd;
  logic [CNT_W-1:0] cand;

  // result
  logic [CNT_W-1:0] res_cnt_r;
  logic             res_pos_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_max_pieces_r;
  logic             out_possible_r;
  logic             out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign too_long = (32'(in_rod_length) > 32'(MAX_LEN));
  assign iss      = (state_r == ST_RUN) && iss_on_r;

  always_comb begin
    for (int k = 0; k < NUM_PIECE; k++) begin
      diff[k]  = CW'(j_r) - CW'(pl_r[k]);
      addr[k]  = diff[k][AW-1:0];
      use_c[k] = (pl_r[k] != '0) && (CW'(pl_r[k]) <= CW'(j_r));
      fwd_c[k] = s2_vld_r && (addr[k] == s2_idx_r);
    end
  end

  // table RAM: two copies written together for three reads per cycle
  logic [ENT_W-1:0] m0_rdata [2];
  logic [ENT_W-1:0] m1_rdata [1];
  logic [AW-1:0]    m0_raddr [2];
  logic [AW-1:0]    m1_raddr [1];

  assign m0_raddr[0] = addr[0];
  assign m0_raddr[1] = addr[1];
  assign m1_raddr[0] = addr[2];

  mcs_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH), .NRD(2)) u_tbl0 (
    .clk     (clk),
    .we      (s2_vld_r),
    .waddr   (s2_idx_r),
    .wdata   (upd),
    .rd_addr (m0_raddr),
    .rd_data (m0_rdata)
  );

  mcs_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH), .NRD(1)) u_tbl1 (
    .clk     (clk),
    .we      (s2_vld_r),
    .waddr   (s2_idx_r),
    .wdata   (upd),
    .rd_addr (m1_raddr),
    .rd_data (m1_rdata)
  );

  always_comb begin
    rd_e[0] = s2_fwd_r[0] ? fwd_r : entry_t'(m0_rdata[0]);
    rd_e[1] = s2_fwd_r[1] ? fwd_r : entry_t'(m0_rdata[1]);
    rd_e[2] = s2_fwd_r[2] ? fwd_r : entry_t'(m1_rdata[0]);
    upd  = '0;
    cand = '0;
    for (int k = 0; k < NUM_PIECE; k++) begin
      cand = rd_e[k].cnt + CNT_W'(1);
      if (s2_use_r[k] && rd_e[k].reach) begin
        if (!upd.reach || (cand > upd.cnt)) begin
          upd.cnt = cand;
        end
        upd.reach = 1'b1;
      end
    end
    if (s2_idx_r == '0) begin
      upd.reach = 1'b1;
      upd.cnt   = '0;
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    iss_on_nxt = iss_on_r;
    n_nxt      = n_r;
    j_nxt      = j_r;
    s2_vld_nxt = iss;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (too_long) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt  = ST_RUN;
            iss_on_nxt = 1'b1;
            n_nxt      = AW'(in_rod_length);
            j_nxt      = '0;
          end
        end
      end
      ST_RUN: begin
        if (iss) begin
          if (j_r == n_r) begin
            iss_on_nxt = 1'b0;
          end else begin
            j_nxt = j_r + AW'(1);
          end
        end
        if (s2_vld_r && s2_last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_on_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iss_on_r <= iss_on_nxt;
      s2_vld_r <= s2_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    j_r       <= j_nxt;
    s2_idx_r  <= j_r;
    s2_last_r <= (j_r == n_r);
    for (int k = 0; k < NUM_PIECE; k++) begin
      s2_use_r[k] <= use_c[k];
      s2_fwd_r[k] <= fwd_c[k];
    end
    if (s2_vld_r) begin
      fwd_r <= upd;
    end
    if (in_acc) begin
      res_cnt_r <= '0;
      res_pos_r <= 1'b0;
    end else if (s2_vld_r && s2_last_r) begin
      res_cnt_r <= upd.cnt;
      res_pos_r <= upd.reach;
    end
    if (out_load) begin
      out_max_pieces_r <= res_cnt_r;
      out_possible_r   <= res_pos_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_max_pieces = out_max_pieces_r;
  assign out_possible   = out_possible_r;

`ifndef SYNTHESIS
  a_s2_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (state_r == ST_RUN))
    else $error("table update outside run state");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised without a finished item");

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_possible_r) |-> (out_max_pieces_r == '0))
    else $error("unreachable length with nonzero count");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss |-> (j_r <= n_r))
    else $error("issue index past rod length");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_last_r) |=> (state_r == ST_DONE) && !s2_vld_r)
    else $error("last entry did not finish the item");
`endif

endmodule

`default_nettype wire

@@ sim/max_cut_segments_dp_checker.sv @@
// ----------------------------------------------------------------------------
// max_cut_segments_dp_checker
// Watches the config port and both item channels of max_cut_segments_dp_top.
// It tracks the piece lengths, rebuilds the count table for every accepted rod
// length up to MAX_LEN and checks each result item in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_cut_segments_dp_checker
  import mcs_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [LEN_W-1:0]  in_rod_length,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [CNT_W-1:0]  out_max_pieces,
  input  wire logic              out_possible,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  input  wire logic              cfg_pready,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [CNT_W-1:0] pieces;
    logic             ok;
  } cut_result_t;

  logic [LEN_W-1:0] piece_len [NUM_PIECE];
  entry_t           count_tbl [0:MAX_LEN];
  cut_result_t      cut_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got_v, want_v);
    fail_count++;
  endtask

  function automatic cut_result_t count_cuts(input logic [LEN_W-1:0] rod);
    cut_result_t      res;
    logic             reach;
    logic [CNT_W:0]   best;
    logic [CNT_W:0]   cand;
    int               prev;
    res = '0;
    if (int'(rod) > MAX_LEN)
      return res;
    count_tbl[0] = '{reach: 1'b1, cnt: '0};
    for (int i = 1; i <= int'(rod); i++) begin
      reach = 1'b0;
      best  = '0;
      for (int k = 0; k < NUM_PIECE; k++) begin
        if (piece_len[k] != '0 && int'(piece_len[k]) <= i) begin
          prev = i - int'(piece_len[k]);
          if (count_tbl[prev].reach) begin
            cand = {1'b0, count_tbl[prev].cnt} + (CNT_W+1)'(1);
            if (!reach || cand > best)
              best = cand;
            reach = 1'b1;
          end
        end
      end
      count_tbl[i] = '{reach: reach, cnt: reach ? best[CNT_W-1:0] : '0};
    end
    if (count_tbl[rod].reach) begin
      res.pieces = count_tbl[rod].cnt;
      res.ok     = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cut_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_PIECE; k++)
        piece_len[k] = PIECE_RST;
      cut_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_PIECE_A: piece_len[0] = cfg_pwdata[LEN_W-1:0];
          REG_PIECE_B: piece_len[1] = cfg_pwdata[LEN_W-1:0];
          REG_PIECE_C: piece_len[2] = cfg_pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (cut_q.size() == 0) begin
          report_mismatch("result with no item pending", int'(out_max_pieces), -1);
        end else begin
          want = cut_q.pop_front();
          if (out_max_pieces !== want.pieces)
            report_mismatch("max_pieces", int'(out_max_pieces), int'(want.pieces));
          if (out_possible !== want.ok)
            report_mismatch("possible", int'(out_possible), int'(want.ok));
        end
      end
      if (in_valid && !in_stall)
        cut_q.push_back(count_cuts(in_rod_length));
    end
    pending = cut_q.size();
  end

endmodule

`default_nettype wire

@@ sim/max_cut_segments_dp_top_tb.sv @@
// ----------------------------------------------------------------------------
// max_cut_segments_dp_top_tb
// Drives rod length items and piece length writes into the block: a short
// directed set of corner cases, then random config groups with mostly
// short rods, under changing sender and receiver idle rates. A checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_cut_segments_dp_top_tb;
  import mcs_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 1500000;
  localparam int         GROUPS      = 8;
  localparam int         GROUP_ITEMS = 24;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [LEN_W-1:0]  in_rod_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CNT_W-1:0]  out_max_pieces;
  logic              out_possible;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending;
  int cycles = 0;
  int tx_idle_pct = 21;
  int rx_idle_pct = 50;

  max_cut_segments_dp_top dut (.*);

  max_cut_segments_dp_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_rod_length,
    .out_valid, .out_stall, .out_max_pieces, .out_possible,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < rx_idle_pct);

  task automatic send_rod(input logic [LEN_W-1:0] rod);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_rod_length <= rod;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] len);
    logic [CFG_DW-1:0] word;
    word = $urandom();
    word[LEN_W-1:0] = len;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_pieces(input logic [LEN_W-1:0] a, b, c);
    drain();
    repeat (8) @(negedge clk);
    write_reg(REG_PIECE_A, a);
    write_reg(REG_PIECE_B, b);
    write_reg(REG_PIECE_C, c);
  endtask

  function automatic logic [LEN_W-1:0] pick_piece;
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 80) return LEN_W'($urandom_range(1, 12));
    if (r < 95) return LEN_W'($urandom_range(13, 200));
    return LEN_W'($urandom_range(201, 2047));
  endfunction

  function automatic logic [LEN_W-1:0] pick_rod;
    int r;
    r = $urandom_range(99);
    if (r < 85) return LEN_W'($urandom_range(0, 63));
    if (r < 95) return LEN_W'($urandom_range(64, 300));
    if (r < 98) return LEN_W'($urandom_range(301, 1024));
    return LEN_W'($urandom_range(1025, 2047));
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset lengths 1/1/1
    send_rod(0);
    send_rod(1);
    send_rod(5);
    send_rod(1024);
    send_rod(1025);
    send_rod(2047);

    // longest legal pieces, plus a write past the last register
    set_pieces(1024, 1024, 1024);
    write_reg(REG_UNUSED, 7);
    send_rod(1024);
    send_rod(1023);
    send_rod(0);

    // no usable piece
    set_pieces(0, 0, 0);
    send_rod(0);
    send_rod(3);

    // oversize and zero pieces next to a short one
    set_pieces(2047, 0, 3);
    send_rod(9);
    send_rod(10);
    send_rod(2047);

    set_pieces(2, 3, 0);
    send_rod(1);
    send_rod(7);
    send_rod(1000);

    set_pieces(5, 3, 1);
    send_rod(11);
    send_rod(1024);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 50 : 0;
      rx_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 21 : 0;
      for (int g = 0; g < GROUPS; g++) begin
        set_pieces(pick_piece(), pick_piece(), pick_piece());
        if ($urandom_range(3) == 0)
          write_reg(REG_UNUSED, LEN_W'($urandom()));
        for (int j = 0; j < GROUP_ITEMS; j++) begin
          if (j == 12)
            drain();
          send_rod(pick_rod());
        end
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/mcs_pkg.sv
hdl/mcs_ram.sv
hdl/max_cut_segments_dp_top.sv
sim/max_cut_segments_dp_checker.sv
sim/max_cut_segments_dp_top_tb.sv
